// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk with async reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/scd_pkg.sv =====
// ---------------------------------------------------------------------------
// Scan code decoder package
// Constants, command codes, pipeline types and the extended key lookup.
// ---------------------------------------------------------------------------
package scd_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // Key codes
    localparam logic [7:0] EXT_PREFIX  = 8'hE0;
    localparam logic [6:0] LSHIFT      = 7'h2A;
    localparam logic [6:0] RSHIFT      = 7'h36;
    localparam logic [6:0] CTRL_KEY    = 7'h1D;
    localparam logic [6:0] CAPS_KEY    = 7'h3A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

    // Config reset values and register indexes
    localparam logic [15:0] HOLD_DELAY_RST      = 16'd500;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd35;
    localparam logic        REG_HOLD_DELAY      = 1'b0;
    localparam logic        REG_REPEAT_INTERVAL = 1'b1;

    // Extended key table
    localparam int EXT_COUNT = 10;
    localparam int EXT_AW    = $clog2(EXT_COUNT);
    localparam logic [6:0] EXT_CODES [EXT_COUNT] = '{
        7'h48, 7'h50, 7'h4B, 7'h4D, 7'h47, 7'h4F, 7'h53, 7'h49, 7'h51, 7'h52
    };

    // Command codes
    typedef enum logic [2:0] {
        OP_SCAN     = 3'd0,
        OP_POP      = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_LOAD_NRM = 3'd3,
        OP_LOAD_SHF = 3'd4,
        OP_LOAD_EXT = 3'd5
    } op_t;

    // Transaction held in the update stage
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  scan_code;
        logic [31:0] now_ms;
        logic [6:0]  table_index;
        logic [7:0]  table_value;
    } item_t;

    // Extended code lookup result
    typedef struct packed {
        logic              hit;
        logic [EXT_AW-1:0] slot;
    } ext_hit_t;

    function automatic ext_hit_t ext_lookup(input logic [6:0] code);
        ext_hit_t r;
        r.hit  = 1'b0;
        r.slot = '0;
        for (int i = 0; i < EXT_COUNT; i++) begin
            if (EXT_CODES[i] == code) begin
                r.hit  = 1'b1;
                r.slot = EXT_AW'(i);
            end
        end
        return r;
    endfunction

    // Ring pointer increment for any depth
    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== sv/scancode_decoder_typematic_fifo_core.sv =====
// ---------------------------------------------------------------------------
// Scan code decoder with typematic repeat and key FIFO
// Set-1 keyboard decoder: layout table RAMs, key byte ring FIFO, modifiers.
// ---------------------------------------------------------------------------
// Two-stage design: on acceptance the normal, shifted and FIFO RAMs are read
// (synchronous read); the update stage then decodes the transaction,
// updates key, modifier and pointer state, writes back the RAMs and loads
// the output register. A new transaction is taken every cycle while no
// stalled result holds the update stage, so the sustained rate is one per
// clock; each result passes through the read registers and the update stage.
// A stalled result holds the update stage, which stalls the input.
// Back-to-back hazards on the same table entry or FIFO slot are forwarded.
// Table RAMs carry per-entry valid bits cleared at reset, so no clearing
// pass is needed and the block accepts transactions right after reset.
module scancode_decoder_typematic_fifo_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [7:0]  scan_code,
    input  logic [31:0] now_ms,
    input  logic [6:0]  table_index,
    input  logic [7:0]  table_value,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_byte,
    output logic        available,
    output logic        shift_down,
    output logic        ctrl_down,
    output logic        caps_on
);

`include "assert_macros.svh"

    localparam int AW = scd_pkg::FIFO_AW;

    // Config registers
    logic [15:0] hold_delay_reg;
    logic [15:0] repeat_interval_reg;

    // Memories
    logic [7:0] normal_mem  [128];
    logic [7:0] shifted_mem [128];
    logic [7:0] fifo_mem    [scd_pkg::FIFO_DEPTH];

    // Valid bits for the table RAMs, key state, extended table
    logic [127:0] normal_vld_reg;
    logic [127:0] shifted_vld_reg;
    logic [127:0] pressed_reg, pressed_next;
    logic [7:0]   ext_table_reg [scd_pkg::EXT_COUNT];

    // Decoder state
    logic [AW-1:0] write_ptr_reg, write_ptr_next;
    logic [AW-1:0] read_ptr_reg, read_ptr_next;
    logic          ext_pending_reg, ext_pending_next;
    logic [6:0]    held_code_reg, held_code_next;
    logic [31:0]   hold_start_reg, hold_start_next;
    logic [31:0]   last_repeat_reg, last_repeat_next;
    logic          shift_reg, shift_next;
    logic          ctrl_reg, ctrl_next;
    logic          caps_reg, caps_next;

    // Update stage
    logic           s1_valid_reg;
    scd_pkg::item_t s1_reg;
    logic [7:0]     nrm_rd_reg, shf_rd_reg, fifo_rd_reg;
    logic           nrm_fwd_reg, shf_fwd_reg, fifo_fwd_reg;
    logic [7:0]     tbl_fwd_val_reg, fifo_fwd_val_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] read_byte_reg;
    logic       available_reg, shift_out_reg, ctrl_out_reg, caps_out_reg;

    // Handshake and control
    logic          commit;
    logic          in_acc;
    logic [AW-1:0] rd_addr;
    logic          nrm_we, shf_we, ext_we;
    logic          fifo_we;
    logic [AW-1:0] fifo_waddr;
    logic [7:0]    fifo_wdata;
    logic [7:0]    rb;

    assign commit   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !commit;
    assign in_acc   = in_valid && !in_stall;
    assign rd_addr  = commit ? read_ptr_next : read_ptr_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_delay_reg      <= scd_pkg::HOLD_DELAY_RST;
            repeat_interval_reg <= scd_pkg::REPEAT_INTERVAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                scd_pkg::REG_HOLD_DELAY:      hold_delay_reg      <= cfg_data;
                scd_pkg::REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
            endcase
        end
    end

    // RAM read ports, registered at acceptance, with same-entry forwarding
    always_ff @(posedge clk) begin
        if (in_acc) begin
            nrm_rd_reg       <= normal_mem[scan_code[6:0]];
            shf_rd_reg       <= shifted_mem[scan_code[6:0]];
            fifo_rd_reg      <= fifo_mem[rd_addr];
            nrm_fwd_reg      <= nrm_we && (s1_reg.table_index == scan_code[6:0]);
            shf_fwd_reg      <= shf_we && (s1_reg.table_index == scan_code[6:0]);
            tbl_fwd_val_reg  <= s1_reg.table_value;
            fifo_fwd_reg     <= fifo_we && (fifo_waddr == rd_addr);
            fifo_fwd_val_reg <= fifo_wdata;
            s1_reg           <= '{op, scan_code, now_ms, table_index, table_value};
        end
    end

    // RAM write ports
    always_ff @(posedge clk) begin
        if (nrm_we) begin
            normal_mem[s1_reg.table_index] <= s1_reg.table_value;
        end
        if (shf_we) begin
            shifted_mem[s1_reg.table_index] <= s1_reg.table_value;
        end
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
    end

    // Decode and state update
    always_comb begin
        logic [6:0]        code;
        logic              go;
        logic              rep_ok;
        logic [31:0]       d_hold, d_rep;
        logic              push_req;
        logic [7:0]        push_byte;
        logic [7:0]        nrm, shf, ch;
        logic              letter;
        logic [AW-1:0]     wnext;
        scd_pkg::ext_hit_t eh;

        write_ptr_next   = write_ptr_reg;
        read_ptr_next    = read_ptr_reg;
        ext_pending_next = ext_pending_reg;
        held_code_next   = held_code_reg;
        hold_start_next  = hold_start_reg;
        last_repeat_next = last_repeat_reg;
        shift_next       = shift_reg;
        ctrl_next        = ctrl_reg;
        caps_next        = caps_reg;
        pressed_next     = pressed_reg;
        nrm_we           = 1'b0;
        shf_we           = 1'b0;
        ext_we           = 1'b0;
        fifo_we          = 1'b0;
        fifo_waddr       = write_ptr_reg;
        fifo_wdata       = '0;
        rb               = '0;
        push_req         = 1'b0;
        push_byte        = '0;
        go               = 1'b0;

        code   = s1_reg.scan_code[6:0];
        d_hold = s1_reg.now_ms - hold_start_reg;
        d_rep  = s1_reg.now_ms - last_repeat_reg;
        rep_ok = (d_hold >= {16'b0, hold_delay_reg}) && (d_rep >= {16'b0, repeat_interval_reg});
        eh     = scd_pkg::ext_lookup(code);
        nrm    = nrm_fwd_reg ? tbl_fwd_val_reg
                             : (normal_vld_reg[code] ? nrm_rd_reg : 8'h00);
        shf    = shf_fwd_reg ? tbl_fwd_val_reg
                             : (shifted_vld_reg[code] ? shf_rd_reg : 8'h00);
        letter = (nrm >= scd_pkg::CH_LOWER_A) && (nrm <= scd_pkg::CH_LOWER_Z);
        ch     = (letter ? (shift_reg != caps_reg) : shift_reg) ? shf : nrm;
        wnext  = scd_pkg::ptr_inc(write_ptr_reg);

        if (commit) begin
            unique case (scd_pkg::op_t'(s1_reg.op))
                scd_pkg::OP_SCAN: begin
                    if (s1_reg.scan_code == scd_pkg::EXT_PREFIX) begin
                        ext_pending_next = 1'b1;
                    end else if (ext_pending_reg) begin
                        // extended key: no press map, table lookup by code
                        ext_pending_next = 1'b0;
                        if (s1_reg.scan_code[7]) begin
                            if (code == held_code_reg) begin
                                held_code_next = '0;
                            end
                        end else begin
                            if (code == held_code_reg) begin
                                if (rep_ok) begin
                                    last_repeat_next = s1_reg.now_ms;
                                    go               = 1'b1;
                                end
                            end else begin
                                held_code_next   = code;
                                hold_start_next  = s1_reg.now_ms;
                                last_repeat_next = s1_reg.now_ms;
                                go               = 1'b1;
                            end
                            if (go && eh.hit) begin
                                push_req  = 1'b1;
                                push_byte = ext_table_reg[eh.slot];
                            end
                        end
                    end else if (s1_reg.scan_code[7]) begin
                        // plain release
                        pressed_next[code] = 1'b0;
                        if (code == held_code_reg) begin
                            held_code_next = '0;
                        end
                        if (code == scd_pkg::LSHIFT || code == scd_pkg::RSHIFT) begin
                            shift_next = 1'b0;
                        end
                        if (code == scd_pkg::CTRL_KEY) begin
                            ctrl_next = 1'b0;
                        end
                    end else begin
                        // plain press, typematic filter
                        if (pressed_reg[code]) begin
                            if (code == held_code_reg && rep_ok) begin
                                last_repeat_next = s1_reg.now_ms;
                                go               = 1'b1;
                            end
                        end else begin
                            pressed_next[code] = 1'b1;
                            held_code_next     = code;
                            hold_start_next    = s1_reg.now_ms;
                            last_repeat_next   = s1_reg.now_ms;
                            go                 = 1'b1;
                        end
                        if (go) begin
                            priority if (code == scd_pkg::LSHIFT || code == scd_pkg::RSHIFT) begin
                                shift_next = 1'b1;
                            end else if (code == scd_pkg::CTRL_KEY) begin
                                ctrl_next = 1'b1;
                            end else if (code == scd_pkg::CAPS_KEY) begin
                                caps_next = !caps_reg;
                            end else begin
                                // unmapped key pushes nothing
                                push_req  = (nrm != 8'h00);
                                push_byte = ch;
                            end
                        end
                    end
                end
                scd_pkg::OP_POP: begin
                    if (write_ptr_reg != read_ptr_reg) begin
                        rb            = fifo_fwd_reg ? fifo_fwd_val_reg : fifo_rd_reg;
                        read_ptr_next = scd_pkg::ptr_inc(read_ptr_reg);
                    end
                end
                scd_pkg::OP_FLUSH: begin
                    write_ptr_next = '0;
                    read_ptr_next  = '0;
                end
                scd_pkg::OP_LOAD_NRM: nrm_we = 1'b1;
                scd_pkg::OP_LOAD_SHF: shf_we = 1'b1;
                scd_pkg::OP_LOAD_EXT: begin
                    ext_we = (s1_reg.table_index < 7'(scd_pkg::EXT_COUNT));
                end
                default: ;
            endcase

            // push into the ring, drop when full
            if (push_req && (wnext != read_ptr_reg)) begin
                fifo_we        = 1'b1;
                fifo_wdata     = push_byte;
                write_ptr_next = wnext;
            end
        end
    end

    // Extended table
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < scd_pkg::EXT_COUNT; i++) begin
                ext_table_reg[i] <= '0;
            end
        end else if (ext_we) begin
            ext_table_reg[s1_reg.table_index[scd_pkg::EXT_AW-1:0]] <= s1_reg.table_value;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            normal_vld_reg  <= '0;
            shifted_vld_reg <= '0;
            pressed_reg     <= '0;
            write_ptr_reg   <= '0;
            read_ptr_reg    <= '0;
            ext_pending_reg <= 1'b0;
            held_code_reg   <= '0;
            hold_start_reg  <= '0;
            last_repeat_reg <= '0;
            shift_reg       <= 1'b0;
            ctrl_reg        <= 1'b0;
            caps_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (in_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
            if (nrm_we) begin
                normal_vld_reg[s1_reg.table_index] <= 1'b1;
            end
            if (shf_we) begin
                shifted_vld_reg[s1_reg.table_index] <= 1'b1;
            end
            pressed_reg     <= pressed_next;
            write_ptr_reg   <= write_ptr_next;
            read_ptr_reg    <= read_ptr_next;
            ext_pending_reg <= ext_pending_next;
            held_code_reg   <= held_code_next;
            hold_start_reg  <= hold_start_next;
            last_repeat_reg <= last_repeat_next;
            shift_reg       <= shift_next;
            ctrl_reg        <= ctrl_next;
            caps_reg        <= caps_next;
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk) begin
        if (commit) begin
            read_byte_reg <= rb;
            available_reg <= (write_ptr_next != read_ptr_next);
            shift_out_reg <= shift_next;
            ctrl_out_reg  <= ctrl_next;
            caps_out_reg  <= caps_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_byte  = read_byte_reg;
    assign available  = available_reg;
    assign shift_down = shift_out_reg;
    assign ctrl_down  = ctrl_out_reg;
    assign caps_on    = caps_out_reg;

    // Assertions
    `ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_reg, "input stalled with empty update stage")
    `ASSERT_NEXT(a_commit_loads_out, commit, out_valid_reg, "committed transaction has no result")
    `ASSERT_NEXT(a_flush_empties, commit && (s1_reg.op == scd_pkg::OP_FLUSH), !available_reg, "flush left FIFO non-empty")
    `ASSERT_IMP(a_ptr_range, 1'b1, (read_ptr_reg <= AW'(scd_pkg::FIFO_DEPTH - 1)) && (write_ptr_reg <= AW'(scd_pkg::FIFO_DEPTH - 1)), "FIFO pointer out of range")

endmodule

// ===== dv/tb_scancode_decoder_typematic_fifo_core.sv =====
// ---------------------------------------------------------------------------
// Scan code decoder testbench
// Sends scan bytes, pops, flushes and table loads to the decoder. A clocked
// driver takes them from a queue of pending commands, and a clocked monitor
// checks every status transaction against an in-bench model of the key
// tracking, typematic timing, modifiers, layout tables and key FIFO. The run
// goes through several hold/repeat timing settings, the extremes among them.
// ---------------------------------------------------------------------------
module tb_scancode_decoder_typematic_fifo_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_HALF    = 5;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [2:0] OP_RSVD6    = 3'd6;
    localparam logic [2:0] OP_RSVD7    = 3'd7;

    // Status carried by one output transaction
    typedef struct packed {
        logic [7:0] read_byte;
        logic       available;
        logic       shift_dn;
        logic       ctrl_dn;
        logic       caps;
    } key_status_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [2:0]  op          = '0;
    logic [7:0]  scan_code   = '0;
    logic [31:0] now_ms      = '0;
    logic [6:0]  table_index = '0;
    logic [7:0]  table_value = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  read_byte;
    logic        available;
    logic        shift_down;
    logic        ctrl_down;
    logic        caps_on;

    // Command and status queues, bookkeeping
    scd_pkg::item_t key_cmd_q [$];
    key_status_t    status_due_q [$];
    int             mismatch_cnt = 0;
    int             cycle_cnt    = 0;
    logic [31:0]    tick_ms      = '0;
    logic [6:0]     hot_keys [6] = '{default: 7'd0};

    // Model state: key FIFO, key map, hold tracking, modifiers, tables
    logic [7:0]  kf_mem [scd_pkg::FIFO_DEPTH];
    int unsigned kf_wr = 0;
    int unsigned kf_rd = 0;
    bit          key_down [128] = '{default: 1'b0};
    bit          ext_armed  = 1'b0;
    logic [6:0]  held_code  = '0;
    logic [31:0] hold_t0    = '0;
    logic [31:0] last_rep_t = '0;
    bit          shift_q    = 1'b0;
    bit          ctrl_q     = 1'b0;
    bit          caps_q     = 1'b0;
    logic [7:0]  nrm_tab [128]               = '{default: 8'd0};
    logic [7:0]  shf_tab [128]               = '{default: 8'd0};
    logic [7:0]  ext_tab [scd_pkg::EXT_COUNT] = '{default: 8'd0};
    logic [15:0] hold_delay_q = scd_pkg::HOLD_DELAY_RST;
    logic [15:0] repeat_gap_q = scd_pkg::REPEAT_INTERVAL_RST;

    scancode_decoder_typematic_fifo_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .scan_code   (scan_code),
        .now_ms      (now_ms),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_byte   (read_byte),
        .available   (available),
        .shift_down  (shift_down),
        .ctrl_down   (ctrl_down),
        .caps_on     (caps_on)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the decoder
    // ------------------------------------------------------------------

    // Held key may repeat once both the hold delay and the interval passed
    function automatic bit repeat_due(logic [31:0] now);
        logic [31:0] since_hold;
        logic [31:0] since_rep;
        since_hold = now - hold_t0;
        since_rep  = now - last_rep_t;
        return (since_hold >= {16'd0, hold_delay_q}) &&
               (since_rep >= {16'd0, repeat_gap_q});
    endfunction

    function automatic void begin_hold(logic [6:0] code, logic [31:0] now);
        held_code  = code;
        hold_t0    = now;
        last_rep_t = now;
    endfunction

    // Ring keeps one slot free; a byte into a full ring is dropped
    function automatic void push_key(logic [7:0] b);
        int unsigned nxt;
        nxt = (kf_wr + 1) % scd_pkg::FIFO_DEPTH;
        if (nxt != kf_rd)
        begin
            kf_mem[kf_wr] = b;
            kf_wr = nxt;
        end
    endfunction

    function automatic logic [7:0] pop_key();
        logic [7:0] b;
        if (kf_wr == kf_rd)
            return 8'd0;
        b = kf_mem[kf_rd];
        kf_rd = (kf_rd + 1) % scd_pkg::FIFO_DEPTH;
        return b;
    endfunction

    // Byte following the extended prefix; no key map update
    function automatic void take_ext(logic [7:0] sc, logic [31:0] now);
        logic [6:0] code;
        code = sc[6:0];
        ext_armed = 1'b0;
        if (sc[7])
        begin
            if (code == held_code)
                held_code = '0;
            return;
        end
        if (code == held_code)
        begin
            if (!repeat_due(now))
                return;
            last_rep_t = now;
        end
        else
            begin_hold(code, now);
        for (int i = 0; i < scd_pkg::EXT_COUNT; i++)
        begin
            if (scd_pkg::EXT_CODES[i] == code)
            begin
                push_key(ext_tab[i]);
                return;
            end
        end
    endfunction

    function automatic void take_scan(logic [7:0] sc, logic [31:0] now);
        logic [6:0] code;
        logic [7:0] ch;
        bit         letter;
        code = sc[6:0];
        if (sc == scd_pkg::EXT_PREFIX)
        begin
            ext_armed = 1'b1;
            return;
        end
        if (ext_armed)
        begin
            take_ext(sc, now);
            return;
        end
        // key release
        if (sc[7])
        begin
            key_down[code] = 1'b0;
            if (code == held_code)
                held_code = '0;
            if (code == scd_pkg::LSHIFT || code == scd_pkg::RSHIFT)
                shift_q = 1'b0;
            if (code == scd_pkg::CTRL_KEY)
                ctrl_q = 1'b0;
            return;
        end
        // press: fresh key, or a repeat of the held one
        if (key_down[code])
        begin
            if (code != held_code)
                return;
            if (!repeat_due(now))
                return;
            last_rep_t = now;
        end
        else
        begin
            key_down[code] = 1'b1;
            begin_hold(code, now);
        end
        if (code == scd_pkg::LSHIFT || code == scd_pkg::RSHIFT)
        begin
            shift_q = 1'b1;
            return;
        end
        if (code == scd_pkg::CTRL_KEY)
        begin
            ctrl_q = 1'b1;
            return;
        end
        if (code == scd_pkg::CAPS_KEY)
        begin
            caps_q = !caps_q;
            return;
        end
        // layout lookup; letters flip on shift xor caps
        ch = nrm_tab[code];
        if (ch == 8'd0)
            return;
        letter = (ch >= scd_pkg::CH_LOWER_A) && (ch <= scd_pkg::CH_LOWER_Z);
        if (letter ? (shift_q != caps_q) : shift_q)
            ch = shf_tab[code];
        push_key(ch);
    endfunction

    function automatic key_status_t predict_status(scd_pkg::item_t it);
        key_status_t s;
        s.read_byte = 8'd0;
        case (it.op)
            scd_pkg::OP_SCAN:     take_scan(it.scan_code, it.now_ms);
            scd_pkg::OP_POP:      s.read_byte = pop_key();
            scd_pkg::OP_FLUSH:
            begin
                kf_wr = 0;
                kf_rd = 0;
            end
            scd_pkg::OP_LOAD_NRM: nrm_tab[it.table_index] = it.table_value;
            scd_pkg::OP_LOAD_SHF: shf_tab[it.table_index] = it.table_value;
            scd_pkg::OP_LOAD_EXT:
            begin
                if (it.table_index < scd_pkg::EXT_COUNT)
                    ext_tab[it.table_index] = it.table_value;
            end
            default: ;
        endcase
        s.available = (kf_wr != kf_rd);
        s.shift_dn  = shift_q;
        s.ctrl_dn   = ctrl_q;
        s.caps      = caps_q;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_error(string msg);
        mismatch_cnt++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Command generation
    // ------------------------------------------------------------------

    task automatic add_item(logic [2:0] op_c, logic [7:0] sc, logic [31:0] now,
                            logic [6:0] idx, logic [7:0] val);
        scd_pkg::item_t it;
        it.op          = op_c;
        it.scan_code   = sc;
        it.now_ms      = now;
        it.table_index = idx;
        it.table_value = val;
        key_cmd_q.push_back(it);
    endtask

    task automatic add_scan(logic [7:0] sc);
        add_item(scd_pkg::OP_SCAN, sc, tick_ms, 7'($urandom), 8'($urandom));
    endtask

    task automatic add_cmd(logic [2:0] op_c, logic [6:0] idx, logic [7:0] val);
        add_item(op_c, 8'($urandom), $urandom(), idx, val);
    endtask

    // Mostly small steps, some around the timing settings, rare jumps
    task automatic step_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            tick_ms += $urandom_range(0, 30);
        else if (r < 95)
            tick_ms += $urandom_range(0, hold_delay_q + repeat_gap_q + 10);
        else if (r < 98)
            tick_ms = $urandom();
    endtask

    function automatic logic [7:0] key_value();
        case ($urandom_range(0, 9))
            0:          return 8'd0;
            1:          return scd_pkg::CH_LOWER_A - 8'd1;
            2:          return scd_pkg::CH_LOWER_Z + 8'd1;
            3, 4, 5, 6: return scd_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
            default:    return 8'($urandom);
        endcase
    endfunction

    function automatic logic [6:0] pick_key(bit ext);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (ext)
            return (r < 70) ? scd_pkg::EXT_CODES[$urandom_range(0, scd_pkg::EXT_COUNT - 1)]
                            : 7'($urandom);
        if (r < 5)
            return 7'd0;
        if (r < 9)
            return scd_pkg::LSHIFT;
        if (r < 13)
            return scd_pkg::RSHIFT;
        if (r < 17)
            return scd_pkg::CTRL_KEY;
        if (r < 21)
            return scd_pkg::CAPS_KEY;
        if (r < 65)
            return hot_keys[$urandom_range(0, 5)];
        return 7'($urandom);
    endfunction

    // Press, a few timed repeats, usually a release
    task automatic gen_stroke(bit ext);
        logic [6:0]  code;
        logic [31:0] t0;
        code = pick_key(ext);
        step_time();
        if (ext)
        begin
            add_scan(scd_pkg::EXT_PREFIX);
            if ($urandom_range(0, 9) == 0)
                add_scan(scd_pkg::EXT_PREFIX);
        end
        add_scan({1'b0, code});
        t0 = tick_ms;
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 2))
                0:       tick_ms += $urandom_range(0, 20);
                1:       tick_ms = t0 + hold_delay_q + $urandom_range(0, 2) - 1;
                default: tick_ms += repeat_gap_q + $urandom_range(0, 2) - 1;
            endcase
            if (ext)
                add_scan(scd_pkg::EXT_PREFIX);
            else if ($urandom_range(0, 5) == 0)
                add_scan({1'b0, pick_key(1'b0)});
            add_scan({1'b0, code});
        end
        if ($urandom_range(0, 4) != 0)
        begin
            step_time();
            if (ext)
                add_scan(scd_pkg::EXT_PREFIX);
            add_scan({1'b1, code});
        end
    endtask

    task automatic gen_phase(int n_items);
        int unsigned r;
        logic [6:0]  code;
        logic [2:0]  ld_op;
        // fresh layout entries for a handful of keys
        foreach (hot_keys[i])
        begin
            hot_keys[i] = 7'($urandom);
            add_cmd(scd_pkg::OP_LOAD_NRM, hot_keys[i], key_value());
            add_cmd(scd_pkg::OP_LOAD_SHF, hot_keys[i], 8'($urandom));
        end
        while (key_cmd_q.size() < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                gen_stroke(1'b0);
            else if (r < 55)
                gen_stroke(1'b1);
            else if (r < 72)
                repeat ($urandom_range(1, 4))
                    add_cmd(scd_pkg::OP_POP, 7'($urandom), 8'($urandom));
            else if (r < 75)
                add_cmd(scd_pkg::OP_FLUSH, 7'($urandom), 8'($urandom));
            else if (r < 83)
            begin
                case ($urandom_range(0, 2))
                    0:       ld_op = scd_pkg::OP_LOAD_NRM;
                    1:       ld_op = scd_pkg::OP_LOAD_SHF;
                    default: ld_op = scd_pkg::OP_LOAD_EXT;
                endcase
                if (ld_op == scd_pkg::OP_LOAD_EXT && $urandom_range(0, 3) != 0)
                    add_cmd(ld_op, 7'($urandom_range(0, 15)), key_value());
                else
                    add_cmd(ld_op, 7'($urandom), key_value());
            end
            else if (r < 85)
                repeat (scd_pkg::FIFO_DEPTH + 2)
                    add_cmd(scd_pkg::OP_POP, 7'($urandom), 8'($urandom));
            else if (r < 90)
            begin
                // typing run of separate strokes
                repeat ($urandom_range(5, 20))
                begin
                    code = pick_key(1'b0);
                    step_time();
                    add_scan({1'b0, code});
                    step_time();
                    add_scan({1'b1, code});
                end
            end
            else
            begin
                // noise: stray bytes, lone prefixes, unused commands
                case ($urandom_range(0, 3))
                    0:
                    begin
                        step_time();
                        add_scan(8'($urandom));
                    end
                    1:       add_scan(scd_pkg::EXT_PREFIX);
                    2:       add_cmd(OP_RSVD6, 7'($urandom), 8'($urandom));
                    default: add_cmd(OP_RSVD7, 7'($urandom), 8'($urandom));
                endcase
            end
        end
    endtask

    // Hold off until every transaction has been answered
    task automatic wait_idle();
        while (key_cmd_q.size() != 0 || in_valid || status_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == scd_pkg::REG_HOLD_DELAY)
            hold_delay_q = val;
        else
            repeat_gap_q = val;
    endtask

    task automatic run_phase(logic [15:0] hold, logic [15:0] gap, int n_items,
                             bit fill);
        write_cfg(scd_pkg::REG_HOLD_DELAY, hold);
        write_cfg(scd_pkg::REG_REPEAT_INTERVAL, gap);
        if (fill)
        begin
            // with zero timing every repeat is taken: overrun the FIFO, drain it
            add_scan(8'h82);
            add_scan(8'h82);
            add_cmd(scd_pkg::OP_LOAD_NRM, 7'h02, 8'h31);
            repeat (scd_pkg::FIFO_DEPTH + 6)
                add_scan(8'h02);
            add_scan(8'h82);
            repeat (scd_pkg::FIFO_DEPTH + 2)
                add_cmd(scd_pkg::OP_POP, 7'($urandom), 8'($urandom));
        end
        gen_phase(n_items);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Driver: one command transaction at a time from the pending queue
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive
        scd_pkg::item_t nxt;
        bit             calm;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            calm = (cycle_cnt >= 600) && (cycle_cnt < 1000);
            if (in_valid && !in_stall)
                status_due_q.push_back(predict_status(
                    scd_pkg::item_t'({op, scan_code, now_ms, table_index, table_value})));
            if (!in_valid || !in_stall)
            begin
                if (key_cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 8))
                begin
                    nxt = key_cmd_q.pop_front();
                    in_valid    <= 1'b1;
                    op          <= nxt.op;
                    scan_code   <= nxt.scan_code;
                    now_ms      <= nxt.now_ms;
                    table_index <= nxt.table_index;
                    table_value <= nxt.table_value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each status transaction with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        key_status_t want;
        bit          calm;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            calm = (cycle_cnt >= 600) && (cycle_cnt < 1000);
            if (out_valid && !out_stall)
            begin
                if (status_due_q.size() == 0)
                    flag_error("status transaction with no command outstanding");
                else
                begin
                    want = status_due_q.pop_front();
                    check_field("read_byte", read_byte, want.read_byte);
                    check_field("available", 8'(available), 8'(want.available));
                    check_field("shift_down", 8'(shift_down), 8'(want.shift_dn));
                    check_field("ctrl_down", 8'(ctrl_down), 8'(want.ctrl_dn));
                    check_field("caps_on", 8'(caps_on), 8'(want.caps));
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 8);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_scancode_decoder_typematic_fifo_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pop on empty, loads, unused command
        add_cmd(scd_pkg::OP_POP, 7'd0, 8'd0);
        add_cmd(scd_pkg::OP_LOAD_NRM, 7'h1E, scd_pkg::CH_LOWER_A);
        add_cmd(scd_pkg::OP_LOAD_SHF, 7'h1E, 8'h41);
        add_cmd(scd_pkg::OP_LOAD_NRM, 7'h02, 8'h31);
        add_cmd(scd_pkg::OP_LOAD_NRM, 7'h7F, 8'hFF);
        add_cmd(scd_pkg::OP_LOAD_EXT, 7'd0, 8'h81);
        add_cmd(scd_pkg::OP_LOAD_EXT, 7'd10, 8'hAA);
        add_cmd(OP_RSVD6, 7'h7F, 8'hFF);
        // press, early press, repeat after the hold delay, release
        tick_ms = 32'd1000;
        add_scan(8'h1E);
        tick_ms = 32'd1100;
        add_scan(8'h1E);
        tick_ms = 32'd1500;
        add_scan(8'h1E);
        add_scan(8'h9E);
        // caps, then shift over a letter and a non-letter with empty shift entry
        add_scan({1'b0, scd_pkg::CAPS_KEY});
        add_scan({1'b0, scd_pkg::LSHIFT});
        add_scan(8'h1E);
        add_scan(8'h02);
        add_scan({1'b1, scd_pkg::LSHIFT});
        // prefix after prefix, mapped and unmapped extended keys
        add_scan(scd_pkg::EXT_PREFIX);
        add_scan(scd_pkg::EXT_PREFIX);
        add_scan(8'h48);
        add_scan(scd_pkg::EXT_PREFIX);
        add_scan(8'h10);
        // code zero across the wrap of the tick count
        tick_ms = 32'hFFFF_FFFF;
        add_scan(8'h00);
        tick_ms = 32'h0000_0000;
        add_scan(8'h00);
        add_scan(8'h7F);
        add_cmd(scd_pkg::OP_POP, 7'd0, 8'd0);
        add_cmd(scd_pkg::OP_FLUSH, 7'd0, 8'd0);
        add_cmd(scd_pkg::OP_POP, 7'd0, 8'd0);

        // random traffic under reset timing, then under other settings
        gen_phase(210);
        wait_idle();
        run_phase(16'd0, 16'd0, 210, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 210, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 210, 1'b0);
        run_phase(16'd20, 16'd5, 210, 1'b0);

        if (mismatch_cnt == 0)
            $display("tb_scancode_decoder_typematic_fifo_core OK");
        else
            $display("tb_scancode_decoder_typematic_fifo_core NOT OK");
        $finish;
    end

endmodule
